// File: design/ufm_pkg.sv
`default_nettype none

package ufm_pkg;

  // Width of the byte position counter inside a frame.
  localparam int POS_W = 16;

  localparam int MAC_W       = 48;
  localparam int LINK_LEN_W  = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int OFS_W       = 7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_MAC     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_HDR_LEN  = 4'd1;

  localparam logic [LINK_LEN_W-1:0] LINK_LEN_RESET = 5'd14;

  // Protocol constants.
  localparam logic [7:0] IP_PROTO_UDP      = 8'h11;
  localparam logic [3:0] IP_VERSION_4      = 4'd4;
  localparam logic [5:0] IP_HDR_DEFAULT    = 6'd20;
  localparam int         MAC_BYTES         = 6;

  // Byte offsets relative to the start of the IP header; OFS_UDP_HDR is the UDP header length
  localparam logic [OFS_W-1:0] OFS_PROTO      = 7'd9;
  localparam logic [OFS_W-1:0] OFS_DPORT      = 7'd22;
  localparam logic [OFS_W-1:0] OFS_MIN_L3     = 7'd28;
  localparam logic [OFS_W-1:0] OFS_UDP_HDR    = 7'd8;
  localparam logic [OFS_W-1:0] OFS_DPORT_UDP  = 7'd2;

  typedef struct packed {
    logic [MAC_W-1:0]      local_mac;
    logic [LINK_LEN_W-1:0] link_len;
  } ufm_cfg_t;

  typedef struct packed {
    logic        udp_for_me;
    logic [5:0]  ip_header_bytes;
    logic [6:0]  headers_total_bytes;
    logic [15:0] dest_port;
  } ufm_result_t;

endpackage

`default_nettype wire

// File: design/ufm_hdr_track.sv
`default_nettype none

module ufm_hdr_track (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         frame_byte,
  input  wire logic               frame_last,
  input  wire ufm_pkg::ufm_cfg_t  cfg,
  output ufm_pkg::ufm_result_t    result
);

  logic [ufm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic        mac_eq_r, mac_eq_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] oport_r, oport_nxt;

  logic [ufm_pkg::OFS_W-1:0] l7, proto_at, dport_at, opt_at, min_at, ip7;
  logic [7:0]  want;
  logic        past_ip_start;
  logic        long_enough;
  logic        match;
  logic [5:0]  ip4;

  always_comb begin
    l7       = {2'b00, cfg.link_len};
    proto_at = l7 + ufm_pkg::OFS_PROTO;
    dport_at = l7 + ufm_pkg::OFS_DPORT;
    min_at   = l7 + ufm_pkg::OFS_MIN_L3;

    case (pos_r[2:0])
      3'd0: want = cfg.local_mac[47:40];
      3'd1: want = cfg.local_mac[39:32];
      3'd2: want = cfg.local_mac[31:24];
      3'd3: want = cfg.local_mac[23:16];
      3'd4: want = cfg.local_mac[15:8];
      3'd5: want = cfg.local_mac[7:0];
      default: want = 8'h00;
    endcase

    mac_eq_nxt = mac_eq_r;
    if (pos_r < ufm_pkg::POS_W'(ufm_pkg::MAC_BYTES) && want != frame_byte) begin
      mac_eq_nxt = 1'b0;
    end

    ver_nxt = ver_r;
    hw_nxt  = hw_r;
    if (pos_r == ufm_pkg::POS_W'(l7)) begin
      ver_nxt = frame_byte[7:4];
      hw_nxt  = frame_byte[3:0];
    end

    proto_nxt = proto_r;
    if (pos_r == ufm_pkg::POS_W'(proto_at)) begin
      proto_nxt = frame_byte;
    end

    dport_nxt = dport_r;
    if (pos_r == ufm_pkg::POS_W'(dport_at)) begin
      dport_nxt[15:8] = frame_byte;
    end
    if (pos_r == ufm_pkg::POS_W'(dport_at + 7'd1)) begin
      dport_nxt[7:0] = frame_byte;
    end

    // The option port follows the IHL seen so far, so it is only tracked
    // once the version/IHL byte has gone by.
    opt_at        = l7 + {1'b0, hw_nxt, 2'b00} + ufm_pkg::OFS_DPORT_UDP;
    past_ip_start = pos_r > ufm_pkg::POS_W'(l7);
    oport_nxt     = oport_r;
    if (past_ip_start && pos_r == ufm_pkg::POS_W'(opt_at)) begin
      oport_nxt[15:8] = frame_byte;
    end
    if (past_ip_start && pos_r == ufm_pkg::POS_W'(opt_at + 7'd1)) begin
      oport_nxt[7:0] = frame_byte;
    end

    pos_nxt = pos_r;
    if (pos_r != {ufm_pkg::POS_W{1'b1}}) begin
      pos_nxt = pos_r + ufm_pkg::POS_W'(1);
    end

    // The frame holds pos_r + 1 bytes; it must exceed link length + 28.
    long_enough = pos_r >= ufm_pkg::POS_W'(min_at);
    match = long_enough && proto_nxt == ufm_pkg::IP_PROTO_UDP &&
            ver_nxt == ufm_pkg::IP_VERSION_4 && mac_eq_nxt;
    ip4 = {hw_nxt, 2'b00};
    ip7 = {1'b0, ip4};

    result.udp_for_me = match;
    if (match) begin
      result.ip_header_bytes = ip4;
      result.dest_port       = oport_nxt;
      if (ip4 > ufm_pkg::IP_HDR_DEFAULT) begin
        result.headers_total_bytes = l7 + ip7 + ufm_pkg::OFS_UDP_HDR;
      end else begin
        result.headers_total_bytes = min_at;
      end
    end else begin
      result.ip_header_bytes     = ufm_pkg::IP_HDR_DEFAULT;
      result.dest_port           = dport_nxt;
      result.headers_total_bytes = l7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_last)) begin
      pos_r    <= '0;
      mac_eq_r <= 1'b1;
      ver_r    <= '0;
      hw_r     <= '0;
      proto_r  <= '0;
      dport_r  <= '0;
      oport_r  <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      mac_eq_r <= mac_eq_nxt;
      ver_r    <= ver_nxt;
      hw_r     <= hw_nxt;
      proto_r  <= proto_nxt;
      dport_r  <= dport_nxt;
      oport_r  <= oport_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/udp_for_me_header_parser_top.sv
`default_nettype none

// Channel  | Direction | Ports                         | Payload
// ---------+-----------+-------------------------------+---------------------------------
// in_      | slave     | tvalid tready tdata tlast     | tdata: frame_byte; tlast: frame_last
// out_     | master    | tvalid tready tdata tuser     | one result request per frame
// cfg_     | slave     | valid ready index data        | 0: local_mac, 1: link_header_len
//
// One byte is accepted per cycle unless a last byte is held in the input register. Each byte is
// registered there and classified by the header tracker as it leaves; a frame's result loads
// into the output register as its last byte leaves, and is valid from then on until taken.
// Reset is synchronous and active low; it clears the frame state and the valid flags of both registers.
// A last byte waits in the input register only while the output holds an untaken result.
// Configuration writes are always accepted.

module udp_for_me_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tlast,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [5:0] ip_header_bytes, [12:6] headers_total_bytes,
                                       // [28:13] dest_port, [31:29] zero
  output logic             out_tuser,  // [0] udp_for_me

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ufm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ufm_pkg::MAC_W-1:0]       cfg_data
);

  ufm_pkg::ufm_cfg_t    cfg_r;
  ufm_pkg::ufm_result_t trk_result;
  ufm_pkg::ufm_result_t res_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_free;
  logic       advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_mac <= '0;
      cfg_r.link_len  <= ufm_pkg::LINK_LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ufm_pkg::REG_LOCAL_MAC) begin
        cfg_r.local_mac <= cfg_data;
      end else if (cfg_index == ufm_pkg::REG_LINK_HDR_LEN) begin
        cfg_r.link_len <= cfg_data[ufm_pkg::LINK_LEN_W-1:0];
      end
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ufm_hdr_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .frame_byte (s1_byte_r),
    .frame_last (s1_last_r),
    .cfg        (cfg_r),
    .result     (trk_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      res_r <= trk_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.udp_for_me;
  assign out_tdata  = {3'b000, res_r.dest_port, res_r.headers_total_bytes,
                       res_r.ip_header_bytes};

endmodule

`default_nettype wire

// File: design/ufm_checker.sv
`default_nettype none

module ufm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A non-matching frame always reports the default IP header size.
  a_nomatch_ip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[5:0] == 6'd20)
    else $error("non-matching frame with non-default IP header size");

  // A matching frame reports a header size in whole words.
  a_match_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == 2'b00 && out_tdata[31:29] == 3'b000)
    else $error("matching frame with odd IP header size");

  // A fresh result rises only after a last byte has been accepted and passed the input register.
  a_rose_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last byte");

endmodule

bind udp_for_me_header_parser_top ufm_checker u_ufm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: test/udp_for_me_header_parser_top_tb.sv
`timescale 1ns / 100ps

module udp_for_me_header_parser_top_tb;

  localparam logic [ufm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [31:0]                     out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ufm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ufm_pkg::MAC_W-1:0]       cfg_data;

  udp_for_me_header_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register copies and per-frame header tracking on the testbench side.
  logic [ufm_pkg::MAC_W-1:0]      mac_cfg = '0;
  logic [ufm_pkg::LINK_LEN_W-1:0] link_cfg = ufm_pkg::LINK_LEN_RESET;
  logic [ufm_pkg::POS_W-1:0]      frame_pos = '0;
  bit                             mac_ok = 1'b1;
  logic [3:0]                     ver_seen = '0;
  logic [3:0]                     ihl_seen = '0;
  logic [7:0]                     proto_seen = '0;
  logic [15:0]                    port_default = '0;
  logic [15:0]                    port_option = '0;

  ufm_pkg::ufm_result_t pending_results[$];
  logic [7:0]           frame_bytes[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  results_seen = 0;
  int  matches_seen = 0;
  int  cfg_writes = 0;
  int  hold_cycles = 0;
  bit  burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Timeout at %0t", $time);
    $display("TEST FAILED");
    $finish;
  end

  task automatic classify_byte(input logic [7:0] b, input logic is_last);
    int p;
    int l;
    int opt_at;
    int ip_bytes;
    int total;
    bit hit;
    logic [ufm_pkg::MAC_W-1:0] shifted;
    logic [15:0] port;
    ufm_pkg::ufm_result_t r;
    p = int'(frame_pos);
    l = int'(link_cfg);
    if (p < ufm_pkg::MAC_BYTES) begin
      shifted = mac_cfg >> (8 * (ufm_pkg::MAC_BYTES - 1 - p));
      if (shifted[7:0] != b) mac_ok = 1'b0;
    end
    if (p == l) begin
      ver_seen = b[7:4];
      ihl_seen = b[3:0];
    end
    if (p == l + ufm_pkg::OFS_PROTO) proto_seen = b;
    if (p == l + ufm_pkg::OFS_DPORT) port_default[15:8] = b;
    if (p == l + ufm_pkg::OFS_DPORT + 1) port_default[7:0] = b;
    // The option offset follows the IHL, which may have been captured on this very byte.
    opt_at = l + 4 * int'(ihl_seen) + ufm_pkg::OFS_DPORT_UDP;
    if (p > l) begin
      if (p == opt_at) port_option[15:8] = b;
      if (p == opt_at + 1) port_option[7:0] = b;
    end
    if (!is_last) begin
      if (frame_pos != '1) frame_pos++;
    end else begin
      hit = (p + 1 > l + ufm_pkg::OFS_MIN_L3) && proto_seen == ufm_pkg::IP_PROTO_UDP &&
            ver_seen == ufm_pkg::IP_VERSION_4 && mac_ok;
      ip_bytes = int'(ufm_pkg::IP_HDR_DEFAULT);
      total = l;
      port = port_default;
      if (hit) begin
        ip_bytes = 4 * int'(ihl_seen);
        total = l + ufm_pkg::OFS_MIN_L3;
        if (ip_bytes > ufm_pkg::IP_HDR_DEFAULT) total = l + ip_bytes + ufm_pkg::OFS_UDP_HDR;
        port = port_option;
      end
      r.udp_for_me = hit;
      r.ip_header_bytes = ip_bytes[5:0];
      r.headers_total_bytes = total[6:0];
      r.dest_port = port;
      pending_results.push_back(r);
      frame_pos = '0;
      mac_ok = 1'b1;
      ver_seen = '0;
      ihl_seen = '0;
      proto_seen = '0;
      port_default = '0;
      port_option = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ufm_pkg::REG_LOCAL_MAC) mac_cfg = cfg_data;
        else if (cfg_index == ufm_pkg::REG_LINK_HDR_LEN)
          link_cfg = cfg_data[ufm_pkg::LINK_LEN_W-1:0];
      end
      if (in_tvalid && in_tready) classify_byte(in_tdata, in_tlast);
    end
  end

  function automatic void check_field(input string name, input int e, input int a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ufm_pkg::ufm_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("udp_for_me", int'(exp_r.udp_for_me), int'(out_tuser));
        check_field("ip_header_bytes", int'(exp_r.ip_header_bytes), int'(out_tdata[5:0]));
        check_field("headers_total_bytes", int'(exp_r.headers_total_bytes),
                    int'(out_tdata[12:6]));
        check_field("dest_port", int'(exp_r.dest_port), int'(out_tdata[28:13]));
        check_field("tdata padding", 0, int'(out_tdata[31:29]));
        results_seen++;
        if (out_tuser) matches_seen++;
      end
    end
  end

  // Result sink: random stall before each result, or a long hold-off on request.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = burst ? 0 : int'($urandom_range(12, 0));
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = burst ? 0 : int'($urandom_range(12, 0));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic send_noise_frame(input int len);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255, 0)));
    send_frame();
  endtask

  // Random payload with the MAC, version/IHL and protocol bytes placed where the
  // current link header length puts them; fields beyond the frame are dropped.
  task automatic send_header_frame(input int len, input logic [ufm_pkg::MAC_W-1:0] mac,
                                   input logic [3:0] ver, input logic [3:0] ihl,
                                   input logic [7:0] proto);
    int l;
    l = int'(link_cfg);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255, 0)));
    for (int i = 0; i < ufm_pkg::MAC_BYTES && i < len; i++)
      frame_bytes[i] = mac[8 * (ufm_pkg::MAC_BYTES - 1 - i) +: 8];
    if (l < len) frame_bytes[l] = {ver, ihl};
    if (l + ufm_pkg::OFS_PROTO < len) frame_bytes[l + ufm_pkg::OFS_PROTO] = proto;
    send_frame();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Let a frame still in the pipeline settle before touching registers.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ufm_pkg::CFG_INDEX_W-1:0] index,
                           input logic [ufm_pkg::MAC_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Let the register copies settle for the next frame.
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [ufm_pkg::MAC_W-1:0] random_mac();
    return ufm_pkg::MAC_W'({$urandom(), $urandom()});
  endfunction

  task automatic test_reset_values();
    // Registers at reset: MAC of all zeros, 14-byte link header.
    send_header_frame(ufm_pkg::LINK_LEN_RESET + 29, '0, ufm_pkg::IP_VERSION_4, 4'd5,
                      ufm_pkg::IP_PROTO_UDP);
    send_header_frame(ufm_pkg::LINK_LEN_RESET + 28, '0, ufm_pkg::IP_VERSION_4, 4'd5,
                      ufm_pkg::IP_PROTO_UDP);
  endtask

  task automatic test_frame_fields();
    logic [ufm_pkg::MAC_W-1:0] mac;
    int l;
    mac = random_mac();
    write_reg(ufm_pkg::REG_LOCAL_MAC, mac);
    l = int'(link_cfg);
    send_header_frame(l + 29, mac, ufm_pkg::IP_VERSION_4, 4'd5, ufm_pkg::IP_PROTO_UDP);
    send_header_frame(l + 29, mac ^ 48'h1, ufm_pkg::IP_VERSION_4, 4'd5, ufm_pkg::IP_PROTO_UDP);
    send_header_frame(l + 29, mac, ufm_pkg::IP_VERSION_4, 4'd5, 8'h10);
    // Largest IHL with the option port inside the frame.
    send_header_frame(l + 64, mac, ufm_pkg::IP_VERSION_4, 4'd15, ufm_pkg::IP_PROTO_UDP);
    // IHL below five is taken as given.
    send_header_frame(l + 30, mac, ufm_pkg::IP_VERSION_4, 4'd0, ufm_pkg::IP_PROTO_UDP);
    // A short frame compares only the MAC bytes it carries.
    send_header_frame(3, mac, ufm_pkg::IP_VERSION_4, 4'd5, ufm_pkg::IP_PROTO_UDP);
  endtask

  task automatic test_register_decode();
    logic [ufm_pkg::MAC_W-1:0] junk;
    // Unused index leaves both registers alone; upper data bits of the length are dropped.
    write_reg(REG_UNUSED, random_mac());
    send_header_frame(int'(link_cfg) + 29, mac_cfg, ufm_pkg::IP_VERSION_4, 4'd5,
                      ufm_pkg::IP_PROTO_UDP);
    junk = random_mac();
    write_reg(ufm_pkg::REG_LINK_HDR_LEN, {junk[42:0], 5'd18});
    send_header_frame(int'(link_cfg) + 29, mac_cfg, ufm_pkg::IP_VERSION_4, 4'd5,
                      ufm_pkg::IP_PROTO_UDP);
  endtask

  task automatic test_link_offsets();
    int offsets[2] = '{0, 31};
    foreach (offsets[k]) begin
      write_reg(ufm_pkg::REG_LINK_HDR_LEN, ufm_pkg::MAC_W'(offsets[k]));
      send_header_frame(offsets[k] + 29, mac_cfg, ufm_pkg::IP_VERSION_4, 4'd5,
                        ufm_pkg::IP_PROTO_UDP);
    end
  endtask

  task automatic test_output_backpressure();
    drain();
    burst = 1'b1;
    hold_cycles = 200;
    for (int i = 0; i < 24; i++) send_noise_frame(int'($urandom_range(3, 1)));
    burst = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    int start_frames;
    int kind;
    int l;
    int hi;
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [ufm_pkg::MAC_W-1:0] mac;
    start_frames = frames_sent;
    while (bytes_sent < 680 || frames_sent - start_frames < 3) begin
      if ($urandom_range(7, 0) == 0) begin
        write_reg(ufm_pkg::REG_LOCAL_MAC, random_mac());
        if ($urandom_range(9, 0) == 0)
          write_reg(ufm_pkg::REG_LINK_HDR_LEN, ufm_pkg::MAC_W'($urandom_range(31, 0)));
        else
          write_reg(ufm_pkg::REG_LINK_HDR_LEN, ufm_pkg::MAC_W'($urandom_range(30, 14)));
      end
      burst = ($urandom_range(3, 0) == 0);
      l = int'(link_cfg);
      kind = int'($urandom_range(9, 0));
      ihl = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
                                        : 4'($urandom_range(15, 5));
      ver = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                        : ufm_pkg::IP_VERSION_4;
      proto = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0))
                                          : ufm_pkg::IP_PROTO_UDP;
      mac = ($urandom_range(9, 0) == 0) ? mac_cfg ^ (48'h1 << $urandom_range(47, 0))
                                        : mac_cfg;
      if (kind <= 6) begin
        hi = l + 4 * int'(ihl) + 12;
        if (hi < l + 40) hi = l + 40;
        send_header_frame(int'($urandom_range(hi, l + 27)), mac, ver, ihl, proto);
      end else if (kind == 7) begin
        send_header_frame(int'($urandom_range(l + 28, 1)), mac, ver, ihl, proto);
      end else begin
        send_noise_frame(int'($urandom_range(64, 1)));
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= ufm_pkg::REG_LOCAL_MAC;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_frame_fields();
    test_register_decode();
    test_link_offsets();
    test_output_backpressure();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Checked %0d results (%0d matches) from %0d frames, %0d bytes, %0d writes.",
             results_seen, matches_seen, frames_sent, bytes_sent, cfg_writes);
    $display("Covered link offsets 0, 14, 18, 31 and random ones, IHL 0 to 15, short and");
    $display("noise frames, and a long output stall with the input held off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ufm_pkg.sv
design/ufm_hdr_track.sv
design/udp_for_me_header_parser_top.sv
design/ufm_checker.sv
test/udp_for_me_header_parser_top_tb.sv
